[src/dpt_pkg.sv]
// shared constants and types for the four-level translation block
package dpt_pkg;

  localparam int TableNodes   = 64;
  localparam int DataPages    = 64;
  localparam int TableEntries = 512;
  localparam int PageBytes    = 4096;

  localparam int NodeW = $clog2(TableNodes);
  localparam int PageW = $clog2(DataPages);
  localparam int IdxW  = 9;
  localparam int OffW  = 12;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusUnmap   = 2'd1;
  localparam logic [1:0] StatusNoSpace = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ALLOC,
    ST_CLR,
    ST_LINK,
    ST_DATA,
    ST_DWAIT,
    ST_OUT
  } state_t;

endpackage

[src/demand_paged_four_level_translation.sv]
// top level: four-level table walk with on-demand node and page allocation
//
// One byte beat at a time. A walk over mapped tables does, per level, a
// registered table read and then a check, then the data page access and
// the result; a new input beat is taken only once the result is taken. A
// byte skipped after a fault in its block goes straight to the result.
// Each newly allocated table node is allocated, cleared one entry per cycle
// over its 512 entries and linked; each new data page is allocated, its
// 4096 bytes cleared one per cycle, and linked; both through the single
// table port or data port. The root table is a 512-entry store cleared by
// a pass over its entries after reset, during which the block is not
// ready. Node and page stores have no reset: they are cleared on allocation.
module demand_paged_four_level_translation
  import dpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [47:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_create_missing,
  input  logic        in_block_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_status
);

  localparam int NodeAw = NodeW + IdxW;
  localparam int PageAw = PageW + OffW;
  // a table entry: valid bit plus node or page index
  localparam int EntW   = 1 + ((NodeW > PageW) ? NodeW : PageW);

  state_t state_r, state_nxt;

  // captured beat
  logic              op_r;
  logic [47:0]       addr_r;
  logic [7:0]        wd_r;
  logic              create_r;
  logic              faulted_r;

  // walk state
  logic [1:0]        lvl_r;
  logic [NodeW-1:0]  node_r;
  logic [PageW-1:0]  page_r;
  logic [NodeW:0]    free_node_r;
  logic [PageW:0]    free_page_r;
  logic [OffW-1:0]   clr_r;   // shared clear counter

  logic [7:0]        rdata_r;
  logic [1:0]        status_r;

  // root table: entry store with registered read
  logic [EntW-1:0]   root_mem [TableEntries];
  logic [EntW-1:0]   root_rd_r;
  logic              root_we;
  logic [IdxW-1:0]   root_waddr;
  logic [EntW-1:0]   root_wdata;

  // node store
  logic              nram_we;
  logic [NodeAw-1:0] nram_addr;
  logic [EntW-1:0]   nram_wdata, nram_rdata;

  // page store
  logic              pram_we;
  logic [PageAw-1:0] pram_addr;
  logic [7:0]        pram_wdata, pram_rdata;

  logic [IdxW-1:0]   idx_cur;
  logic              ent_vld;
  logic [EntW-1:0]   ent_tgt;
  logic              ent_ok;
  logic [2:0]        need_nodes;
  logic              alloc_page_now;

  dpt_ram #(.Width(EntW), .Depth(TableNodes * TableEntries)) u_node_ram (
    .clk(clk), .we(nram_we), .addr(nram_addr), .wdata(nram_wdata), .rdata(nram_rdata)
  );

  dpt_ram #(.Width(8), .Depth(DataPages * PageBytes)) u_page_ram (
    .clk(clk), .we(pram_we), .addr(pram_addr), .wdata(pram_wdata), .rdata(pram_rdata)
  );

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[root_waddr] <= root_wdata;
    end
    root_rd_r <= root_mem[idx_cur];
  end

  // index for the current level: bits 47..39, 38..30, 29..21, 20..12
  always_comb begin
    case (lvl_r)
      2'd0:    idx_cur = addr_r[47:39];
      2'd1:    idx_cur = addr_r[38:30];
      2'd2:    idx_cur = addr_r[29:21];
      default: idx_cur = addr_r[20:12];
    endcase
  end

  // entry seen in the check cycle; level 0 comes from the root store
  always_comb begin
    if (lvl_r == 2'd0) begin
      ent_vld = root_rd_r[EntW-1];
      ent_tgt = {1'b0, root_rd_r[EntW-2:0]};
    end else begin
      ent_vld = nram_rdata[EntW-1];
      ent_tgt = {1'b0, nram_rdata[EntW-2:0]};
    end
    if (lvl_r == 2'd3) begin
      ent_ok = ent_vld && (ent_tgt < EntW'(DataPages));
    end else begin
      ent_ok = ent_vld && (ent_tgt < EntW'(TableNodes));
    end
  end

  assign need_nodes = 3'd3 - {1'b0, lvl_r};
  assign alloc_page_now = (lvl_r == 2'd3);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (clr_r == OffW'(TableEntries - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_block_start && faulted_r) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD:  state_nxt = ST_CHK;
      ST_CHK: begin
        if (ent_ok) begin
          state_nxt = (lvl_r == 2'd3) ? ST_DATA : ST_RD;
        end else if (!op_r || !create_r) begin
          state_nxt = ST_OUT;
        end else if ((free_node_r + (NodeW+1)'(need_nodes) > (NodeW+1)'(TableNodes))
                     || (free_page_r >= (PageW+1)'(DataPages))) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_ALLOC;
        end
      end
      ST_ALLOC: state_nxt = ST_CLR;
      ST_CLR: begin
        if (alloc_page_now ? (clr_r == OffW'(PageBytes - 1))
                           : (clr_r == OffW'(TableEntries - 1))) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK:  state_nxt = alloc_page_now ? ST_DATA : ST_ALLOC;
      ST_DATA:  state_nxt = ST_DWAIT;
      ST_DWAIT: state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    nram_we    = 1'b0;
    nram_addr  = {node_r, idx_cur};
    nram_wdata = '0;
    pram_we    = 1'b0;
    pram_addr  = {page_r, addr_r[OffW-1:0]};
    pram_wdata = wd_r;
    root_we    = 1'b0;
    root_waddr = addr_r[47:39];
    root_wdata = '0;
    case (state_r)
      ST_INIT: begin
        // clear pass over the root table
        root_we    = 1'b1;
        root_waddr = clr_r[IdxW-1:0];
      end
      ST_CLR: begin
        if (alloc_page_now) begin
          pram_we   = 1'b1;
          pram_addr = {page_r, clr_r};
          pram_wdata = '0;
        end else begin
          nram_we   = 1'b1;
          nram_addr = {free_node_r[NodeW-1:0] - NodeW'(1), clr_r[IdxW-1:0]};
        end
      end
      ST_LINK: begin
        // parent entry of the fresh node or page
        if (lvl_r == 2'd0) begin
          root_we    = 1'b1;
          root_wdata = {1'b1, (EntW-1)'(free_node_r[NodeW-1:0] - NodeW'(1))};
        end else begin
          nram_we    = 1'b1;
          nram_addr  = {node_r, idx_cur};
          nram_wdata = alloc_page_now ? {1'b1, (EntW-1)'(page_r)}
                                      : {1'b1, (EntW-1)'(free_node_r[NodeW-1:0] - NodeW'(1))};
        end
      end
      ST_DATA: pram_we = op_r;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      faulted_r   <= 1'b0;
      free_node_r <= '0;
      free_page_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_block_start) faulted_r <= 1'b0;
          end
        end
        ST_CHK: begin
          if (!ent_ok && (!op_r || !create_r || state_nxt == ST_OUT)) begin
            faulted_r <= 1'b1;
          end
        end
        ST_ALLOC: begin
          if (alloc_page_now) free_page_r <= free_page_r + (PageW+1)'(1);
          else                free_node_r <= free_node_r + (NodeW+1)'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      case (state_r)
        ST_INIT: clr_r <= clr_r + OffW'(1);
        ST_IDLE: begin
          op_r     <= in_opcode;
          addr_r   <= in_address;
          wd_r     <= in_write_data;
          create_r <= in_create_missing;
          lvl_r    <= 2'd0;
          rdata_r  <= '0;
          status_r <= StatusUnmap;
        end
        ST_CHK: begin
          if (ent_ok) begin
            if (lvl_r == 2'd3) begin
              page_r <= ent_tgt[PageW-1:0];
            end else begin
              node_r <= ent_tgt[NodeW-1:0];
              lvl_r  <= lvl_r + 2'd1;
            end
          end else if (op_r && create_r && state_nxt == ST_OUT) begin
            status_r <= StatusNoSpace;
          end
        end
        ST_ALLOC: begin
          clr_r <= '0;
          if (alloc_page_now) page_r <= free_page_r[PageW-1:0];
        end
        ST_CLR: clr_r <= clr_r + OffW'(1);
        ST_LINK: begin
          if (!alloc_page_now) begin
            node_r <= free_node_r[NodeW-1:0] - NodeW'(1);
            lvl_r  <= lvl_r + 2'd1;
          end
        end
        ST_DWAIT: begin
          status_r <= StatusOk;
          rdata_r  <= op_r ? 8'd0 : pram_rdata;
        end
        default: ;
      endcase
    end
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_read_data = rdata_r;
  assign out_status    = status_r;

endmodule

[src/dpt_ram.sv]
// generic single-port ram with registered read
module dpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/dpt_checker.sv]
// port-level checks for the translation block
module dpt_checker
  import dpt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [1:0] out_status
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == StatusOk || out_status == StatusUnmap ||
                   out_status == StatusNoSpace)) else $error("bad status");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != StatusOk) |-> out_read_data == 8'd0)
    else $error("fault with data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");

endmodule

bind demand_paged_four_level_translation dpt_checker u_dpt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_read_data(out_read_data), .out_status(out_status)
);
